// File: sv/kdci_pkg.sv
// Shared types and constants for the two-axis kinematic integrator.
`default_nettype none
package kdci_pkg;

  localparam int unsigned QW     = 32;
  localparam int unsigned MAGW   = 31;
  localparam int unsigned DTW    = 16;
  localparam int unsigned CFG_IW = 3;

  // Configuration register indexes.
  localparam logic [CFG_IW-1:0] REG_ACCEL_X  = 3'd0;
  localparam logic [CFG_IW-1:0] REG_ACCEL_Y  = 3'd1;
  localparam logic [CFG_IW-1:0] REG_DRAG_X   = 3'd2;
  localparam logic [CFG_IW-1:0] REG_DRAG_Y   = 3'd3;
  localparam logic [CFG_IW-1:0] REG_MAX_X    = 3'd4;
  localparam logic [CFG_IW-1:0] REG_MAX_Y    = 3'd5;
  localparam logic [CFG_IW-1:0] REG_LIMIT_EN = 3'd6;

  localparam logic ACT_ADVANCE = 1'b0;
  localparam logic ACT_LOAD    = 1'b1;

  // Sequencer phase in which both lanes have their results ready to commit.
  localparam logic [2:0] LAST_PHASE = 3'd4;

  typedef struct packed {
    logic                   action;
    logic [DTW-1:0]         elapsed;
    logic signed [QW-1:0]   load_pos_x;
    logic signed [QW-1:0]   load_pos_y;
    logic signed [QW-1:0]   load_vel_x;
    logic signed [QW-1:0]   load_vel_y;
  } in_item_t;

  typedef struct packed {
    logic signed [QW-1:0]   pos_x;
    logic signed [QW-1:0]   pos_y;
    logic signed [QW-1:0]   vel_x;
    logic signed [QW-1:0]   vel_y;
    logic                   moved;
    logic                   saturated;
  } out_item_t;

  typedef struct packed {
    logic signed [QW-1:0]   accel;
    logic [MAGW-1:0]        drag;
    logic [MAGW-1:0]        max_speed;
    logic                   limit_on;
  } axis_cfg_t;

  typedef struct packed {
    logic signed [QW-1:0]   pos;
    logic signed [QW-1:0]   vel;
    logic                   moved;
    logic                   saturated;
  } axis_res_t;

endpackage
`default_nettype wire

// File: sv/kdci_lane.sv
// One axis lane: velocity target, clamp, midpoint position update and axis state.
`default_nettype none
module kdci_lane (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire kdci_pkg::axis_cfg_t                cfg,
  input  wire logic [kdci_pkg::DTW-1:0]           dt,
  input  wire logic                               load,
  input  wire logic signed [kdci_pkg::QW-1:0]     load_pos,
  input  wire logic signed [kdci_pkg::QW-1:0]     load_vel,
  input  wire logic                               commit,
  output kdci_pkg::axis_res_t                     res
);

  logic signed [kdci_pkg::QW-1:0] pos_r, vel_r;

  logic signed [48:0] prod_r, pm_r;
  logic signed [kdci_pkg::QW-1:0] tpre_r, t_r, vmid_r;
  logic vsat2_r, vsat3_r, vsat4_r;

  logic acc_nz, drg_nz;
  logic signed [16:0] dt_s;
  logic signed [kdci_pkg::QW-1:0] mul_a;
  logic signed [48:0] prod_nxt, pm_nxt;

  assign acc_nz = (cfg.accel != '0);
  assign drg_nz = (cfg.drag != '0);
  assign dt_s   = $signed({1'b0, dt});
  assign mul_a  = acc_nz ? cfg.accel : $signed({1'b0, cfg.drag});
  assign prod_nxt = mul_a * dt_s;

  // Target velocity before the speed limit.
  logic signed [32:0] k;
  logic signed [33:0] v34, k34, s_acc, s_dn, s_dp;
  logic signed [kdci_pkg::QW-1:0] tpre_nxt;
  logic vsat_nxt;

  always_comb begin
    k     = prod_r[48:16];
    v34   = {{2{vel_r[31]}}, vel_r};
    k34   = {k[32], k};
    s_acc = v34 + k34;
    s_dn  = v34 - k34;
    s_dp  = v34 + k34;
    vsat_nxt = 1'b0;
    tpre_nxt = vel_r;
    if (acc_nz) begin
      if (s_acc[33:31] != 3'b000 && s_acc[33:31] != 3'b111) begin
        vsat_nxt = 1'b1;
        tpre_nxt = s_acc[33] ? $signed({1'b1, 31'd0}) : $signed({1'b0, {31{1'b1}}});
      end else begin
        tpre_nxt = s_acc[31:0];
      end
    end else if (drg_nz) begin
      // Drag pulls toward zero and never crosses it.
      if (!s_dn[33] && s_dn != '0) begin
        tpre_nxt = s_dn[31:0];
      end else if (s_dp[33]) begin
        tpre_nxt = s_dp[31:0];
      end else begin
        tpre_nxt = '0;
      end
    end
  end

  // Speed limit and midpoint velocity.
  logic signed [32:0] t33, v33, lim33, nlim33, tc33, d33, h33, vm33;

  always_comb begin
    t33    = {tpre_r[31], tpre_r};
    v33    = {vel_r[31], vel_r};
    lim33  = $signed({2'b00, cfg.max_speed});
    nlim33 = -lim33;
    tc33   = t33;
    if (cfg.limit_on && tpre_r != '0) begin
      if (t33 > lim33) begin
        tc33 = lim33;
      end else if (t33 < nlim33) begin
        tc33 = nlim33;
      end
    end
    d33  = tc33 - v33;
    h33  = d33 >>> 1;
    vm33 = v33 + h33;
  end

  assign pm_nxt = vmid_r * dt_s;

  // Position update with saturation.
  logic signed [32:0] delta;
  logic signed [33:0] psum;
  logic signed [kdci_pkg::QW-1:0] pos_adv, pos_nxt, vel_nxt;
  logic psat, sat_nxt;

  always_comb begin
    delta = pm_r[48:16];
    psum  = {{2{pos_r[31]}}, pos_r} + {delta[32], delta};
    psat  = (psum[33:31] != 3'b000 && psum[33:31] != 3'b111);
    if (psat) begin
      pos_adv = psum[33] ? $signed({1'b1, 31'd0}) : $signed({1'b0, {31{1'b1}}});
    end else begin
      pos_adv = psum[31:0];
    end
    if (load) begin
      pos_nxt = load_pos;
      vel_nxt = load_vel;
      sat_nxt = 1'b0;
    end else begin
      pos_nxt = pos_adv;
      vel_nxt = t_r;
      sat_nxt = psat | vsat4_r;
    end
  end

  assign res.pos       = pos_nxt;
  assign res.vel       = vel_nxt;
  assign res.moved     = (pos_nxt != pos_r);
  assign res.saturated = sat_nxt;

  // The stages run freely; item and lane state hold steady in flight, but configuration is not held.
  always_ff @(posedge clk) begin
    prod_r  <= prod_nxt;
    tpre_r  <= tpre_nxt;
    vsat2_r <= vsat_nxt;
    t_r     <= tc33[31:0];
    vmid_r  <= vm33[31:0];
    vsat3_r <= vsat2_r;
    pm_r    <= pm_nxt;
    vsat4_r <= vsat3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      vel_r <= '0;
    end else if (commit) begin
      pos_r <= pos_nxt;
      vel_r <= vel_nxt;
    end
  end

endmodule
`default_nettype wire

// File: sv/kdci_merge.sv
// Merge stage: combines both lanes into one result item and holds it in the output register.
`default_nettype none
module kdci_merge (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 commit,
  input  wire kdci_pkg::axis_res_t  res_x,
  input  wire kdci_pkg::axis_res_t  res_y,
  input  wire logic                 out_stall,
  output logic                      out_valid,
  output kdci_pkg::out_item_t       out_data
);

  logic                out_valid_r;
  kdci_pkg::out_item_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_data_r.pos_x     <= res_x.pos;
      out_data_r.pos_y     <= res_y.pos;
      out_data_r.vel_x     <= res_x.vel;
      out_data_r.vel_y     <= res_y.vel;
      out_data_r.moved     <= res_x.moved | res_y.moved;
      out_data_r.saturated <= res_x.saturated | res_y.saturated;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// File: sv/kinematic_drag_clamp_integrator.sv
// One item in flight at a time: in_stall stays high from the accepting edge until the commit.
// Each item takes five steps from capture to commit (two multiplies with the target, clamp and
// midpoint steps between them), then the sequencer idles; commit waits on a stalled output.
// A finished item waits in the output register; the next item may be taken meanwhile.
// Reset (rst_n low, synchronous) clears position, velocity, configuration registers and control.
// Top level: configuration registers, item capture, sequencer, two lanes and merge.
`default_nettype none
module kinematic_drag_clamp_integrator (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire kdci_pkg::in_item_t                 in_data,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output kdci_pkg::out_item_t                     out_data,
  input  wire logic                               cfg_we,
  input  wire logic [kdci_pkg::CFG_IW-1:0]        cfg_index,
  input  wire logic [kdci_pkg::QW-1:0]            cfg_wdata
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_BUSY = 1'b1;

  logic signed [kdci_pkg::QW-1:0] accel_x_r, accel_y_r;
  logic [kdci_pkg::MAGW-1:0]      drag_x_r, drag_y_r, max_x_r, max_y_r;
  logic [1:0]                     limit_en_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_x_r  <= '0;
      accel_y_r  <= '0;
      drag_x_r   <= '0;
      drag_y_r   <= '0;
      max_x_r    <= '0;
      max_y_r    <= '0;
      limit_en_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        kdci_pkg::REG_ACCEL_X:  accel_x_r  <= cfg_wdata;
        kdci_pkg::REG_ACCEL_Y:  accel_y_r  <= cfg_wdata;
        kdci_pkg::REG_DRAG_X:   drag_x_r   <= cfg_wdata[kdci_pkg::MAGW-1:0];
        kdci_pkg::REG_DRAG_Y:   drag_y_r   <= cfg_wdata[kdci_pkg::MAGW-1:0];
        kdci_pkg::REG_MAX_X:    max_x_r    <= cfg_wdata[kdci_pkg::MAGW-1:0];
        kdci_pkg::REG_MAX_Y:    max_y_r    <= cfg_wdata[kdci_pkg::MAGW-1:0];
        kdci_pkg::REG_LIMIT_EN: limit_en_r <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  logic               state_r, state_nxt;
  logic [2:0]         phase_r, phase_nxt;
  kdci_pkg::in_item_t item_r;
  logic               accept, commit;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  // The last step waits while the output register still holds an untaken item.
  assign commit   = (state_r == ST_BUSY) && (phase_r == kdci_pkg::LAST_PHASE)
                    && (!out_valid || !out_stall);

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_BUSY;
          phase_nxt = '0;
        end
      end
      ST_BUSY: begin
        if (commit) begin
          state_nxt = ST_IDLE;
        end else if (phase_r != kdci_pkg::LAST_PHASE) begin
          phase_nxt = phase_r + 3'd1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
    end
  end

  kdci_pkg::axis_cfg_t cfg_x, cfg_y;
  kdci_pkg::axis_res_t res_x, res_y;
  logic                is_load;

  assign cfg_x.accel     = accel_x_r;
  assign cfg_x.drag      = drag_x_r;
  assign cfg_x.max_speed = max_x_r;
  assign cfg_x.limit_on  = limit_en_r[0];
  assign cfg_y.accel     = accel_y_r;
  assign cfg_y.drag      = drag_y_r;
  assign cfg_y.max_speed = max_y_r;
  assign cfg_y.limit_on  = limit_en_r[1];
  assign is_load         = (item_r.action == kdci_pkg::ACT_LOAD);

  kdci_lane u_lane_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_x),
    .dt       (item_r.elapsed),
    .load     (is_load),
    .load_pos (item_r.load_pos_x),
    .load_vel (item_r.load_vel_x),
    .commit   (commit),
    .res      (res_x)
  );

  kdci_lane u_lane_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_y),
    .dt       (item_r.elapsed),
    .load     (is_load),
    .load_pos (item_r.load_pos_y),
    .load_vel (item_r.load_vel_y),
    .commit   (commit),
    .res      (res_y)
  );

  kdci_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .commit    (commit),
    .res_x     (res_x),
    .res_y     (res_y),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
